// File: rtl/smbd_pkg.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw package
// Constants and request codes shared by the generator and its arithmetic units.
// ----------------------------------------------------------------------------
package smbd_pkg;

    // Word width of the generator state and of the mixed output.
    localparam int WORD_W = 64;

    // Default width of the bound used for bounded requests.
    localparam int BOUND_WIDTH_DEF = 32;

    // SplitMix64 increment and mixer constants.
    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    // Mixer shift amounts.
    localparam int SHIFT_1    = 30;
    localparam int SHIFT_2    = 27;
    localparam int SHIFT_3    = 31;
    localparam int UNIT_SHIFT = 11;

    // Request codes.
    localparam logic [1:0] REQ_RAW     = 2'd0;
    localparam logic [1:0] REQ_BOUNDED = 2'd1;
    localparam logic [1:0] REQ_UNIT    = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

endpackage

// File: rtl/smbd_mul.sv
// ----------------------------------------------------------------------------
// SplitMix64 iterative multiplier
// Low 64 bits of a 64x64 product, built from three 32x32 partial products
// on one shared multiplier, one partial product per cycle.
// ----------------------------------------------------------------------------
module smbd_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [smbd_pkg::WORD_W-1:0] i_a,
    input  logic [smbd_pkg::WORD_W-1:0] i_b,
    output logic                       o_done,
    output logic [smbd_pkg::WORD_W-1:0] o_product
);

    localparam int HALF_W = smbd_pkg::WORD_W / 2;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_HL = 2'd1;
    localparam logic [1:0] STEP_LH = 2'd2;

    logic [smbd_pkg::WORD_W-1:0] r_a;
    logic [smbd_pkg::WORD_W-1:0] r_b;
    logic [smbd_pkg::WORD_W-1:0] r_acc;
    logic [1:0]                  r_step;
    logic                        r_busy;
    logic                        r_done;

    logic [HALF_W-1:0]           w_op_a;
    logic [HALF_W-1:0]           w_op_b;
    logic [smbd_pkg::WORD_W-1:0] w_prod;

    // Operand selection for the current partial product.
    always_comb begin
        case (r_step)
            STEP_LL: begin
                w_op_a = r_a[HALF_W-1:0];
                w_op_b = r_b[HALF_W-1:0];
            end
            STEP_HL: begin
                w_op_a = r_a[smbd_pkg::WORD_W-1:HALF_W];
                w_op_b = r_b[HALF_W-1:0];
            end
            STEP_LH: begin
                w_op_a = r_a[HALF_W-1:0];
                w_op_b = r_b[smbd_pkg::WORD_W-1:HALF_W];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = {{HALF_W{1'b0}}, w_op_a} * {{HALF_W{1'b0}}, w_op_b};

    // Sequencing of the three partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                if (r_step == STEP_LH) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_step <= STEP_LL;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    // Operand capture and accumulation; cross terms only reach the upper half.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_step == STEP_LL) begin
                r_acc <= w_prod;
            end else begin
                r_acc[smbd_pkg::WORD_W-1:HALF_W] <=
                    r_acc[smbd_pkg::WORD_W-1:HALF_W] + w_prod[HALF_W-1:0];
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: rtl/smbd_mod.sv
// ----------------------------------------------------------------------------
// SplitMix64 iterative remainder unit
// Restoring remainder of a 64-bit dividend by a narrow divisor, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module smbd_mod #(
    parameter int DIV_WIDTH = smbd_pkg::BOUND_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smbd_pkg::WORD_W-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]        i_divisor,
    output logic                        o_done,
    output logic [DIV_WIDTH-1:0]        o_rem
);

    localparam int CNT_W = $clog2(smbd_pkg::WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(smbd_pkg::WORD_W - 1);

    logic [smbd_pkg::WORD_W-1:0] r_dvd;
    logic [DIV_WIDTH-1:0]        r_div;
    logic [DIV_WIDTH-1:0]        r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [DIV_WIDTH:0]          w_trial;
    logic [DIV_WIDTH:0]          w_diff;
    logic                        w_fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign w_trial = {r_rem, r_dvd[smbd_pkg::WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    // Bit counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[smbd_pkg::WORD_W-2:0], 1'b0};
            r_rem <= w_fits ? w_diff[DIV_WIDTH-1:0] : w_trial[DIV_WIDTH-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/splitmix64_bounded_draw_unit.sv
// ----------------------------------------------------------------------------
// SplitMix64 bounded draw unit
// SplitMix64 generator serving raw, unit-fraction and unbiased bounded draws.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready) with
//   i_req_type and i_bound. One result transaction per request leaves on the
//   output channel (o_out_valid / i_out_ready). Request code 3 is taken and
//   dropped without a result. The seed channel (i_cfg_valid / o_cfg_ready)
//   loads i_seed_value into the generator state; it is ready while idle.
//   Sequence: an accepted raw or unit request passes through the state add,
//   two 64-bit multiplies on a shared 32x32 multiplier, the draw check and
//   the output load. A bounded request with bound of two or more runs the
//   threshold remainder, then the state add, multiplies and draw check for
//   every draw including rejected draws, then the final remainder and the
//   output load. A bound below two goes straight to the output load and
//   presents zeros. The next request can be accepted in the cycle the result
//   appears; the unit computes one request at a time.
//   Reset clears the generator state to zero and empties the output.
//   When the receiver stalls, the result waits in the output register; the
//   unit still takes the next request, then holds its result and accepts no
//   further request until the output register is free.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_unit #(
    parameter int BOUND_WIDTH = smbd_pkg::BOUND_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Seed write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_seed_value,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_bound,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_raw_word,
    output logic [31:0] o_index_value,
    output logic [52:0] o_unit_fraction
);

    localparam int W  = smbd_pkg::WORD_W;
    // Only the low 32 bits of the bound port can ever be significant.
    localparam int BW = (BOUND_WIDTH < 32) ? BOUND_WIDTH : 32;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_THR  = 3'd1;
    localparam logic [2:0] S_ADV  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_IDX  = 3'd6;
    localparam logic [2:0] S_LOAD = 3'd7;

    // Control registers
    logic [2:0]    r_state,     n_state;
    logic [W-1:0]  r_gen,       n_gen;
    logic          r_out_valid, n_out_valid;

    // Per-request working registers
    logic [1:0]    r_req,  n_req;
    logic [BW-1:0] r_bnd,  n_bnd;
    logic [BW-1:0] r_thr,  n_thr;
    logic [W-1:0]  r_word, n_word;
    logic [31:0]   r_idx,  n_idx;

    // Output payload
    logic [63:0]   r_raw_word;
    logic [31:0]   r_index_value;
    logic [52:0]   r_unit_fraction;

    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_load;
    logic [BW-1:0] w_bnd_in;

    logic          w_mul_start;
    logic [W-1:0]  w_mul_a;
    logic [W-1:0]  w_mul_b;
    logic          w_mul_done;
    logic [W-1:0]  w_mul_p;

    logic          w_mod_start;
    logic [W-1:0]  w_mod_dvd;
    logic [BW-1:0] w_mod_div;
    logic          w_mod_done;
    logic [BW-1:0] w_mod_rem;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_bnd_in    = i_bound[BW-1:0];

    // Shared 64-bit multiplier for both mixer rounds.
    smbd_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p)
    );

    // Shared remainder unit for the threshold and the final index.
    smbd_mod #(
        .DIV_WIDTH (BW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (w_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Request sequencer.
    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_out_valid = r_out_valid && !i_out_ready;
        n_req       = r_req;
        n_bnd       = r_bnd;
        n_thr       = r_thr;
        n_word      = r_word;
        n_idx       = r_idx;
        w_load      = 1'b0;
        w_mul_start = 1'b0;
        w_mul_a     = w_mul_p;
        w_mul_b     = smbd_pkg::MIX_MUL_A;
        w_mod_start = 1'b0;
        w_mod_dvd   = r_word;
        w_mod_div   = r_bnd;

        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    n_gen = i_seed_value;
                end
                if (w_in_acc) begin
                    n_req  = i_req_type;
                    n_bnd  = w_bnd_in;
                    n_word = '0;
                    n_idx  = '0;
                    case (i_req_type)
                        smbd_pkg::REQ_RAW,
                        smbd_pkg::REQ_UNIT: begin
                            n_state = S_ADV;
                        end
                        smbd_pkg::REQ_BOUNDED: begin
                            if (|w_bnd_in[BW-1:1]) begin
                                // Threshold is (2^64 - bound) mod bound.
                                w_mod_start = 1'b1;
                                w_mod_dvd   = W'(0) - W'(w_bnd_in);
                                w_mod_div   = w_bnd_in;
                                n_state     = S_THR;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_THR: begin
                if (w_mod_done) begin
                    n_thr   = w_mod_rem;
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                // Advance the state and start the first mixer round.
                n_gen       = r_gen + smbd_pkg::GOLDEN_INC;
                w_mul_a     = n_gen ^ (n_gen >> smbd_pkg::SHIFT_1);
                w_mul_b     = smbd_pkg::MIX_MUL_A;
                w_mul_start = 1'b1;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                if (w_mul_done) begin
                    w_mul_a     = w_mul_p ^ (w_mul_p >> smbd_pkg::SHIFT_2);
                    w_mul_b     = smbd_pkg::MIX_MUL_B;
                    w_mul_start = 1'b1;
                    n_state     = S_MUL2;
                end
            end
            S_MUL2: begin
                if (w_mul_done) begin
                    n_word  = w_mul_p ^ (w_mul_p >> smbd_pkg::SHIFT_3);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_req == smbd_pkg::REQ_BOUNDED) begin
                    // Reject draws below the threshold to keep the index unbiased.
                    if (r_word < W'(r_thr)) begin
                        n_state = S_ADV;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = S_IDX;
                    end
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_IDX: begin
                if (w_mod_done) begin
                    n_idx   = 32'(w_mod_rem);
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_bnd  <= n_bnd;
        r_thr  <= n_thr;
        r_word <= n_word;
        r_idx  <= n_idx;
        if (w_load) begin
            r_raw_word    <= r_word;
            r_index_value <= r_idx;
            r_unit_fraction <= (r_req == smbd_pkg::REQ_UNIT)
                             ? r_word[W-1:smbd_pkg::UNIT_SHIFT] : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_raw_word      = r_raw_word;
    assign o_index_value   = r_index_value;
    assign o_unit_fraction = r_unit_fraction;

    // The final remainder only starts on a draw that passed the threshold.
    a_idx_above_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDX) |-> (r_word >= W'(r_thr)))
        else $error("index remainder started on a rejected draw");

    // A bounded index with a bound of two or more is always below its bound.
    a_idx_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_req == smbd_pkg::REQ_BOUNDED && (|r_bnd[BW-1:1]))
        |-> (r_idx < 32'(r_bnd)))
        else $error("bounded index not below bound");

    // Multiplier results only come back while a mixer round is pending.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MUL1 || r_state == S_MUL2))
        else $error("multiplier finished outside a mixer round");

    // Remainder results only come back while one is awaited.
    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_THR || r_state == S_IDX))
        else $error("remainder unit finished while not awaited");

endmodule
